[rtl/qrv_pkg.sv]
// shared constants and types for the quaternion vector rotation pipeline
package qrv_pkg;

	localparam int QUAT_W = 16;
	localparam int PROD_W = 2 * QUAT_W;
	localparam int COEF_W = 2 * QUAT_W + 2;
	localparam int VEC_WIDTH_DEF = 24;
	localparam int QUAT_FRAC_DEF = 14;
	localparam int NUM_AXES = 3;

	typedef logic signed [QUAT_W-1:0] quat_t;
	typedef logic signed [PROD_W-1:0] qprod_t;
	typedef logic signed [COEF_W-1:0] coef_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} qrv_adv_t;

endpackage

[rtl/qrv_coef.sv]
// rotation matrix coefficients from quaternion parts, two register stages
module qrv_coef (
	input  logic                             clk,
	input  qrv_pkg::qrv_adv_t                adv,
	input  qrv_pkg::quat_t                   quat_w,
	input  qrv_pkg::quat_t                   quat_x,
	input  qrv_pkg::quat_t                   quat_y,
	input  qrv_pkg::quat_t                   quat_z,
	output qrv_pkg::coef_t                   coef_s2 [qrv_pkg::NUM_AXES][qrv_pkg::NUM_AXES]
);
	import qrv_pkg::*;

	qprod_t ww_s1, xx_s1, yy_s1, zz_s1, xy_s1, wz_s1, wy_s1, xz_s1, yz_s1, wx_s1;
	coef_t e_ww, e_xx, e_yy, e_zz, e_xy, e_wz, e_wy, e_xz, e_yz, e_wx;

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			ww_s1 <= quat_w * quat_w;
			xx_s1 <= quat_x * quat_x;
			yy_s1 <= quat_y * quat_y;
			zz_s1 <= quat_z * quat_z;
			xy_s1 <= quat_x * quat_y;
			wz_s1 <= quat_w * quat_z;
			wy_s1 <= quat_w * quat_y;
			xz_s1 <= quat_x * quat_z;
			yz_s1 <= quat_y * quat_z;
			wx_s1 <= quat_w * quat_x;
		end
	end

	assign e_ww = COEF_W'(ww_s1);
	assign e_xx = COEF_W'(xx_s1);
	assign e_yy = COEF_W'(yy_s1);
	assign e_zz = COEF_W'(zz_s1);
	assign e_xy = COEF_W'(xy_s1);
	assign e_wz = COEF_W'(wz_s1);
	assign e_wy = COEF_W'(wy_s1);
	assign e_xz = COEF_W'(xz_s1);
	assign e_yz = COEF_W'(yz_s1);
	assign e_wx = COEF_W'(wx_s1);

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			coef_s2[0][0] <= e_ww + e_xx - e_yy - e_zz;
			coef_s2[0][1] <= (e_xy - e_wz) <<< 1;
			coef_s2[0][2] <= (e_wy + e_xz) <<< 1;
			coef_s2[1][0] <= (e_xy + e_wz) <<< 1;
			coef_s2[1][1] <= e_ww - e_xx + e_yy - e_zz;
			coef_s2[1][2] <= (e_yz - e_wx) <<< 1;
			coef_s2[2][0] <= (e_xz - e_wy) <<< 1;
			coef_s2[2][1] <= (e_yz + e_wx) <<< 1;
			coef_s2[2][2] <= e_ww - e_xx - e_yy + e_zz;
		end
	end

endmodule

[rtl/qrv_dot.sv]
// one rotated component: products, sum with floor shift, clamp
module qrv_dot #(
	parameter int VEC_WIDTH      = qrv_pkg::VEC_WIDTH_DEF,
	parameter int QUAT_FRAC_BITS = qrv_pkg::QUAT_FRAC_DEF
) (
	input  logic                        clk,
	input  qrv_pkg::qrv_adv_t           adv,
	input  qrv_pkg::coef_t              coef [qrv_pkg::NUM_AXES],
	input  logic signed [VEC_WIDTH-1:0] vec [qrv_pkg::NUM_AXES],
	output logic signed [VEC_WIDTH-1:0] rot_s5,
	output logic                        sat_s5
);
	import qrv_pkg::*;

	localparam int PROD_W = COEF_W + VEC_WIDTH;
	localparam int SUM_W = PROD_W + 2;
	localparam int SHIFT = 2 * QUAT_FRAC_BITS;
	localparam int SHR_W = SUM_W - SHIFT;
	localparam logic signed [SHR_W-1:0] MAXV =
		{{(SHR_W - VEC_WIDTH + 1){1'b0}}, {(VEC_WIDTH - 1){1'b1}}};
	localparam logic signed [SHR_W-1:0] MINV =
		{{(SHR_W - VEC_WIDTH + 1){1'b1}}, {(VEC_WIDTH - 1){1'b0}}};

	logic signed [PROD_W-1:0] prod_s3 [NUM_AXES];
	logic signed [SUM_W-1:0]  sum;
	logic signed [SUM_W-1:0]  sum_shr;
	logic signed [SHR_W-1:0]  sum_s4;

	always_ff @(posedge clk) begin
		if (adv.s3) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				prod_s3[i] <= coef[i] * vec[i];
			end
		end
	end

	assign sum = SUM_W'(prod_s3[0]) + SUM_W'(prod_s3[1]) + SUM_W'(prod_s3[2]);
	assign sum_shr = sum >>> SHIFT;

	always_ff @(posedge clk) begin
		if (adv.s4) begin
			sum_s4 <= sum_shr[SHR_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s5) begin
			priority if (sum_s4 > MAXV) begin
				rot_s5 <= MAXV[VEC_WIDTH-1:0];
				sat_s5 <= 1'b1;
			end else if (sum_s4 < MINV) begin
				rot_s5 <= MINV[VEC_WIDTH-1:0];
				sat_s5 <= 1'b1;
			end else begin
				rot_s5 <= sum_s4[VEC_WIDTH-1:0];
				sat_s5 <= 1'b0;
			end
		end
	end

endmodule

[rtl/quaternion_rotate_vector.sv]
// top level: five-stage pipeline rotating a vector by a quaternion
// path: an accepted word moves through stages s1 to s5 in order and is presented from the s5 registers
// throughput: one word per cycle while out_stall is low, set by the fully pipelined multiplier stages
// stalls back up stage by stage; empty stages keep filling while the output waits
// reset clears the stage valid bits only; the data path registers are not reset
module quaternion_rotate_vector #(
	parameter int VEC_WIDTH      = qrv_pkg::VEC_WIDTH_DEF,
	parameter int QUAT_FRAC_BITS = qrv_pkg::QUAT_FRAC_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  qrv_pkg::quat_t              quat_w,
	input  qrv_pkg::quat_t              quat_x,
	input  qrv_pkg::quat_t              quat_y,
	input  qrv_pkg::quat_t              quat_z,
	input  logic signed [VEC_WIDTH-1:0] vec_x,
	input  logic signed [VEC_WIDTH-1:0] vec_y,
	input  logic signed [VEC_WIDTH-1:0] vec_z,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [VEC_WIDTH-1:0] rot_x,
	output logic signed [VEC_WIDTH-1:0] rot_y,
	output logic signed [VEC_WIDTH-1:0] rot_z,
	output logic                        saturated
);
	import qrv_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;
	qrv_adv_t adv;

	logic signed [VEC_WIDTH-1:0] vec_s1 [NUM_AXES];
	logic signed [VEC_WIDTH-1:0] vec_s2 [NUM_AXES];
	coef_t coef_s2 [NUM_AXES][NUM_AXES];
	logic sat_x, sat_y, sat_z;

	// a stage can load when it is empty or its word moves on
	assign rdy5 = !v_s5 || !out_stall;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;

	assign in_stall = !rdy1;

	assign adv.s1 = rdy1 && in_valid;
	assign adv.s2 = rdy2 && v_s1;
	assign adv.s3 = rdy3 && v_s2;
	assign adv.s4 = rdy4 && v_s3;
	assign adv.s5 = rdy5 && v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			vec_s1[0] <= vec_x;
			vec_s1[1] <= vec_y;
			vec_s1[2] <= vec_z;
		end
		if (adv.s2) begin
			vec_s2 <= vec_s1;
		end
	end

	qrv_coef u_coef (
		.clk     (clk),
		.adv     (adv),
		.quat_w  (quat_w),
		.quat_x  (quat_x),
		.quat_y  (quat_y),
		.quat_z  (quat_z),
		.coef_s2 (coef_s2)
	);

	qrv_dot #(
		.VEC_WIDTH      (VEC_WIDTH),
		.QUAT_FRAC_BITS (QUAT_FRAC_BITS)
	) u_dot_x (
		.clk    (clk),
		.adv    (adv),
		.coef   (coef_s2[0]),
		.vec    (vec_s2),
		.rot_s5 (rot_x),
		.sat_s5 (sat_x)
	);

	qrv_dot #(
		.VEC_WIDTH      (VEC_WIDTH),
		.QUAT_FRAC_BITS (QUAT_FRAC_BITS)
	) u_dot_y (
		.clk    (clk),
		.adv    (adv),
		.coef   (coef_s2[1]),
		.vec    (vec_s2),
		.rot_s5 (rot_y),
		.sat_s5 (sat_y)
	);

	qrv_dot #(
		.VEC_WIDTH      (VEC_WIDTH),
		.QUAT_FRAC_BITS (QUAT_FRAC_BITS)
	) u_dot_z (
		.clk    (clk),
		.adv    (adv),
		.coef   (coef_s2[2]),
		.vec    (vec_s2),
		.rot_s5 (rot_z),
		.sat_s5 (sat_z)
	);

	assign out_valid = v_s5;
	assign saturated = sat_x || sat_y || sat_z;

	a_free_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("input stalled while output flows");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v_s1 && v_s2 && v_s3 && v_s4 && v_s5))
		else $error("input stalled with an empty stage");

	a_accept_load: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> v_s1)
		else $error("accepted word not held in first stage");

endmodule
